[design/mmi_pkg.sv]
package mmi_pkg;

  localparam int DATA_W            = 32;
  localparam int SLOT_W            = 3;
  localparam int PC_W              = 4;
  localparam int S_TDATA_W         = 40;
  localparam int M_TDATA_W         = 32;
  localparam int MAX_PEERS_DEFAULT = 8;

  localparam logic [PC_W-1:0] PEER_COUNT_RESET = 4'd3;

  // candidate word travelling down the cell chain
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
  } mmi_tok_t;

endpackage

[design/mmi_cell.sv]
module mmi_cell #(
  parameter int CNT_W = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [mmi_pkg::DATA_W-1:0] wr_data,
  input  logic                    active,
  input  mmi_pkg::mmi_tok_t       tok_in,
  input  logic [CNT_W-1:0]        below_in,
  input  logic [CNT_W-1:0]        same_in,
  output mmi_pkg::mmi_tok_t       tok_out,
  output logic [CNT_W-1:0]        below_out,
  output logic [CNT_W-1:0]        same_out,
  output logic [mmi_pkg::DATA_W-1:0] entry
);
  import mmi_pkg::*;

  logic is_below;
  logic is_same;

  // this cell's entry against the passing candidate
  assign is_below = active && tok_in.valid && (entry < tok_in.value);
  assign is_same  = active && tok_in.valid && (entry == tok_in.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry         <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      if (wr_en) begin
        entry <= wr_data;
      end
      tok_out.valid <= tok_in.valid;
    end
    tok_out.value <= tok_in.value;
    below_out     <= below_in + CNT_W'(is_below);
    same_out      <= same_in + CNT_W'(is_same);
  end

endmodule

[design/majority_match_index_unit.sv]
// channel   | dir | handshake        | payload (low bit first)
// s_tdata   | in  | s_tvalid/tready  | peer_slot[2:0], match_index[34:3], zero pad
// m_tdata   | out | m_tvalid/tready  | majority_index[31:0]
// cfg_wdata | in  | cfg_wen          | peer_count[3:0]
//
// m_tvalid rises once a word is accepted and each of the n candidates,
// n being the active peer count, has walked through the chain of MAX_PEERS
// compare cells, one cell a cycle
// the input is ready again as soon as the result sits in the output
// register, so the next sweep runs while that result waits for m_tready
// rst is synchronous: table cleared to zero, peer_count back to 3
module majority_match_index_unit #(
  parameter int MAX_PEERS = mmi_pkg::MAX_PEERS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [mmi_pkg::S_TDATA_W-1:0] s_tdata,  // peer_slot, match_index, pad
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [mmi_pkg::M_TDATA_W-1:0] m_tdata,  // majority_index
  input  logic                         cfg_wen,
  input  logic [mmi_pkg::PC_W-1:0]     cfg_wdata   // peer_count
);
  import mmi_pkg::*;

  localparam int SEL_W  = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CNT_W  = $clog2(MAX_PEERS + 1);
  localparam int STEP_W = $clog2(2 * MAX_PEERS);
  localparam int CMP_W  = (STEP_W > PC_W) ? STEP_W : PC_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [PC_W-1:0]   peer_count;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] res_next;

  logic [SLOT_W-1:0] peer_slot;
  logic [DATA_W-1:0] match_index;
  logic              s_accept;

  logic [CMP_W-1:0]  n;
  logic [CMP_W-1:0]  rank_k;
  logic [CMP_W-1:0]  last_step;

  // chain links: index 0 feeds the first cell, MAX_PEERS leaves the last
  mmi_tok_t          tok   [MAX_PEERS+1];
  logic [CNT_W-1:0]  below [MAX_PEERS+1];
  logic [CNT_W-1:0]  same  [MAX_PEERS+1];
  logic [DATA_W-1:0] entry [MAX_PEERS];

  logic [MAX_PEERS-1:0] wr_en;
  logic [MAX_PEERS-1:0] active;

  logic [CMP_W-1:0] exit_below;
  logic [CMP_W-1:0] exit_upper;
  logic             exit_hit;

  assign peer_slot   = s_tdata[SLOT_W-1:0];
  assign match_index = s_tdata[SLOT_W +: DATA_W];
  assign s_tready    = (state == ST_IDLE);
  assign s_accept    = s_tvalid && s_tready;

  // active peers: zero counts as one, saturate at table depth
  always_comb begin
    if (peer_count == '0) begin
      n = CMP_W'(1);
    end else if (CMP_W'(peer_count) > CMP_W'(MAX_PEERS)) begin
      n = CMP_W'(MAX_PEERS);
    end else begin
      n = CMP_W'(peer_count);
    end
  end

  // lower median position, (n - 1) / 2
  assign rank_k    = (n - CMP_W'(1)) >> 1;
  // last candidate leaves the last cell this many steps into the sweep
  assign last_step = n - CMP_W'(1) + CMP_W'(MAX_PEERS);

  // candidate injection, one slot per step
  assign tok[0].valid = (state == ST_RUN) && (CMP_W'(step) < n);
  assign tok[0].value = entry[step[SEL_W-1:0]];
  assign below[0]     = '0;
  assign same[0]      = '0;

  for (genvar j = 0; j < MAX_PEERS; j++) begin : g_cell
    assign wr_en[j]  = s_accept && (CMP_W'(peer_slot) == CMP_W'(j))
                       && (CMP_W'(peer_slot) < n);
    assign active[j] = (CMP_W'(j) < n);

    mmi_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (wr_en[j]),
      .wr_data   (match_index),
      .active    (active[j]),
      .tok_in    (tok[j]),
      .below_in  (below[j]),
      .same_in   (same[j]),
      .tok_out   (tok[j+1]),
      .below_out (below[j+1]),
      .same_out  (same[j+1]),
      .entry     (entry[j])
    );
  end

  // a candidate whose rank span covers k is the answer; all such are equal
  assign exit_below = CMP_W'(below[MAX_PEERS]);
  assign exit_upper = CMP_W'(below[MAX_PEERS]) + CMP_W'(same[MAX_PEERS]);
  assign exit_hit   = tok[MAX_PEERS].valid && (exit_below <= rank_k)
                      && (rank_k < exit_upper);

  always_comb begin
    res_next = res;
    if (exit_hit) begin
      res_next = tok[MAX_PEERS].value;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (CMP_W'(step) == last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      peer_count <= PEER_COUNT_RESET;
      m_tvalid   <= 1'b0;
      step       <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        peer_count <= cfg_wdata;
      end
      if (s_accept) begin
        step <= '0;
      end else if (state == ST_RUN) begin
        step <= step + STEP_W'(1);
      end
      // output register: loaded when the sweep is done, cleared when taken
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= res;
    end
  end

endmodule

[design/mmi_checker.sv]
module mmi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mmi_pkg::M_TDATA_W-1:0] m_tdata
);
  import mmi_pkg::*;

  logic [1:0] pending;
  logic       s_acc;
  logic       m_acc;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  // words accepted whose result has not yet been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(s_acc) - 2'(m_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_tready ##1 !$rose(m_tvalid))
    else $error("input taken again or result too early");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_acc |-> pending != 2'd0)
    else $error("result without an accepted word");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many words outstanding");

endmodule

bind majority_match_index_unit mmi_checker u_mmi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[bench/tb_majority_match_index_unit.sv]
// scoreboard: keeps its own copy of the per-peer match table and the peer count,
// works out the majority index for every accepted input word and checks
// the output words against it in order
class majority_scoreboard;
  bit [mmi_pkg::DATA_W-1:0] match_table [mmi_pkg::MAX_PEERS_DEFAULT];
  bit [mmi_pkg::PC_W-1:0]   peer_count;
  bit [mmi_pkg::DATA_W-1:0] majority_q [$];
  int                       errors;

  function new();
    foreach (match_table[i]) match_table[i] = '0;
    peer_count = mmi_pkg::PEER_COUNT_RESET;
    errors     = 0;
  endfunction

  // peer count as the block uses it: zero counts as one, saturates at the table size
  function int active_peers();
    int n;
    n = peer_count;
    if (n == 0) n = 1;
    if (n > mmi_pkg::MAX_PEERS_DEFAULT) n = mmi_pkg::MAX_PEERS_DEFAULT;
    return n;
  endfunction

  function void write_peer_count(bit [mmi_pkg::PC_W-1:0] value);
    peer_count = value;
  endfunction

  function void note_word(bit [mmi_pkg::SLOT_W-1:0] slot, bit [mmi_pkg::DATA_W-1:0] index);
    bit [mmi_pkg::DATA_W-1:0] ranked [mmi_pkg::MAX_PEERS_DEFAULT];
    bit [mmi_pkg::DATA_W-1:0] v;
    int n;
    int j;
    n = active_peers();
    if (slot < n) match_table[slot] = index;
    // insertion sort of the active slots, ascending; ties stay side by side
    for (int i = 0; i < n; i++) begin
      v = match_table[i];
      j = i;
      while (j > 0 && ranked[j-1] > v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    majority_q.insert(majority_q.size(), ranked[(n - 1) / 2]);
  endfunction

  function void check_word(bit [mmi_pkg::DATA_W-1:0] majority_index);
    bit [mmi_pkg::DATA_W-1:0] want;
    if (majority_q.size() == 0) begin
      $error("majority_index: no word expected, actual %08h", majority_index);
      errors++;
    end else begin
      want = majority_q.pop_front();
      if (majority_index !== want) begin
        $error("majority_index: expected %08h actual %08h", want, majority_index);
        errors++;
      end
    end
  endfunction

  function int pending();
    return majority_q.size();
  endfunction
endclass

module tb_majority_match_index_unit;
  import mmi_pkg::*;

  // generous bound: ~1500 words at worst-case latency plus long stalls on both sides
  localparam int CYCLE_LIMIT   = 400000;
  // covers the longest sweep, with n = 8, plus margin
  localparam int SETTLE_CYCLES = 24;
  localparam int CHUNK_WORDS   = 100;
  localparam int CHUNKS        = 5;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // peer_slot[2:0], match_index[34:3], zero pad[39:35]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // majority_index[31:0]
  logic                 cfg_wen;
  logic [PC_W-1:0]      cfg_wdata; // peer_count[3:0]

  majority_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int cycles;

  majority_match_index_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: checks each accepted word, then stalls at random for the next edge
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offers one word and holds it until the edge at which it is taken;
  // valid is only lowered when an idle cycle really follows, so it never
  // falls and rises in the same step
  task automatic send_word(input logic [SLOT_W-1:0] slot, input logic [DATA_W-1:0] index);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - SLOT_W - DATA_W){1'b0}}, index, slot};
    do @(posedge clk); while (!s_tready);
    sb.note_word(slot, index);
  endtask

  // sender holds off until every expected word is back and the sweep has settled
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only while the block is idle
  task automatic set_peer_count(input logic [PC_W-1:0] value);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.write_peer_count(value);
  endtask

  // random word: mostly active slots, values biased towards small numbers
  // (lots of ties) and the top of the range, the rest uniform
  task automatic send_random_word();
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] index;
    if ($urandom_range(3) != 0) slot = SLOT_W'($urandom_range(sb.active_peers() - 1));
    else slot = SLOT_W'($urandom_range(MAX_PEERS_DEFAULT - 1));
    case ($urandom_range(9))
      0:       index = '0;
      1:       index = '1;
      2, 3, 4: index = DATA_W'($urandom_range(7));
      5:       index = 32'hFFFF_FFFF - DATA_W'($urandom_range(7));
      default: index = DATA_W'($urandom);
    endcase
    send_word(slot, index);
  endtask

  initial begin
    int pc_plan [12];
    int plan_pos;
    pc_plan   = '{8, 1, 0, 15, 2, 5, 7, 4, 3, 6, 9, 13};
    sb        = new();
    clk       = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    cycles    = 0;
    plan_pos  = 0;
    send_idle_pct = 26;
    recv_idle_pct = 76;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset peer count of three first
    send_word(3'd0, 32'hFFFF_FFFF);
    send_word(3'd2, 32'hFFFF_FFFF);
    send_word(3'd1, 32'd7);
    send_word(3'd5, 32'd12345);        // slot outside the active peers, ignored
    send_word(3'd0, 32'd0);
    // peer count zero behaves as one
    set_peer_count(4'd0);
    send_word(3'd0, 32'hA5A5_A5A5);
    send_word(3'd3, 32'd1);            // ignored
    // peer count above the table size saturates
    set_peer_count(4'd15);
    send_word(3'd7, 32'hFFFF_FFFF);
    send_word(3'd6, 32'h8000_0000);
    send_word(3'd4, 32'h5555_5555);
    send_word(3'd3, 32'hAAAA_AAAA);
    send_word(3'd5, 32'h8000_0000);    // tie with slot 6
    set_peer_count(4'd8);
    send_word(3'd1, 32'h8000_0000);
    send_word(3'd2, 32'd1);
    set_peer_count(4'd1);
    send_word(3'd0, 32'd0);
    send_word(3'd7, 32'hFFFF_FFFF);    // ignored
    // two peers: majority is the smaller of the two
    set_peer_count(4'd2);
    send_word(3'd1, 32'h1234_5678);
    send_word(3'd0, 32'hFFFF_FFFF);

    // random part in three idling phases, peer count changed between chunks
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 26; recv_idle_pct = 76; end
        1: begin send_idle_pct = 76; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        if (plan_pos < 12) set_peer_count(PC_W'(pc_plan[plan_pos]));
        else set_peer_count(PC_W'($urandom_range(15)));
        plan_pos++;
        for (int k = 0; k < CHUNK_WORDS; k++) begin
          // now and then let the pipe run completely dry
          if ($urandom_range(63) == 0) wait_drained();
          send_random_word();
        end
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
